// ===== hdl/rbs_pkg.sv =====
// Shared constants for the rolling beta slope block.
package rbs_pkg;
  localparam int SAMPLE_W       = 24;
  localparam int BETA_W         = 32;
  localparam int LEN_W          = 9;
  localparam int FRAC_W         = 16;
  localparam int WINDOW_MAX_DEF = 256;
  localparam int WINDOW_LEN_RST = 10;
  localparam int WINDOW_LEN_MIN = 2;
endpackage

// ===== hdl/rolling_beta_slope.sv =====
// Rolling regression slope: beta = (n*Sxy - Sx*Sy) / (n*Syy - Sy*Sy), Q16.16, saturated.
// Processing is shorter while the window fills and when the variance is zero or the quotient
// overflows; an output stall lengthens it. The input stalls until the result is registered.
// The time is set by the 32-step restoring divider and by the shared multiplier, which builds
// the four sum products and the two cross products one per cycle; a second multiplier scales
// Sxy and Syy by n.
// Reset (synchronous, rst high) clears sums, fill count and slot, sets window_len to 10.
module rolling_beta_slope #(
  parameter int WINDOW_MAX = rbs_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [rbs_pkg::LEN_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rbs_pkg::SAMPLE_W-1:0] x_sample,
  input  logic signed [rbs_pkg::SAMPLE_W-1:0] y_sample,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rbs_pkg::BETA_W-1:0]   beta,
  output logic                                beta_valid
);

  localparam int SW  = rbs_pkg::SAMPLE_W;
  localparam int QW  = rbs_pkg::BETA_W;
  localparam int AW  = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
  localparam int LW  = $clog2(WINDOW_MAX + 1);
  localparam int SXW = SW + AW;           // sum_x, sum_y
  localparam int SQW = 2 * SW + AW;       // sum_yy, sum_xy
  localparam int NW  = SQW + LW + 2;      // numerator / denominator
  localparam int XW  = NW + QW + 2;       // divider datapath
  localparam int CW  = $clog2(QW);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_M1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_M3   = 4'd4;
  localparam logic [3:0] ST_SUM  = 4'd5;
  localparam logic [3:0] ST_P0   = 4'd6;
  localparam logic [3:0] ST_P1   = 4'd7;
  localparam logic [3:0] ST_P2   = 4'd8;
  localparam logic [3:0] ST_DSET = 4'd9;
  localparam logic [3:0] ST_DIV  = 4'd10;
  localparam logic [3:0] ST_RND  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  localparam logic [QW-1:0] POS_LIM = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIM = {1'b1, {(QW-1){1'b0}}};

  logic [3:0] state;

  logic [LW-1:0] wlen;
  logic [LW-1:0] fill_count;
  logic [AW-1:0] write_slot;
  logic [AW-1:0] slot;
  logic          full;

  logic signed [SXW-1:0] sum_x, sum_y;
  logic signed [SQW-1:0] sum_yy, sum_xy;

  logic signed [SW-1:0] xs, ys, ox, oy;
  logic signed [SW-1:0] x_mem [WINDOW_MAX];
  logic signed [SW-1:0] y_mem [WINDOW_MAX];

  logic signed [SXW-1:0]     ma, mb;
  logic signed [2*SXW-1:0]   p;
  logic signed [SQW-1:0]     sc_in;
  logic signed [LW+SQW:0]    s;

  logic signed [NW-1:0] num, den;
  logic [NW-1:0]        mag;
  logic                 neg;
  logic [XW-1:0]        rem, dsh;
  logic [QW-1:0]        q;
  logic [CW-1:0]        cnt;
  logic [QW-1:0]        res_beta;
  logic                 res_valid;

  logic          in_acc;
  logic [AW-1:0] slot_sel;
  logic [LW-1:0] fill_after;
  logic [LW:0]   slot_inc;
  logic [XW-1:0] dvd, dvsr;
  logic [LW-1:0] wlen_wr;
  logic [QW-1:0] qv;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    if (restart || ((LW+1)'(write_slot) >= (LW+1)'(wlen))) begin
      slot_sel = '0;
    end else begin
      slot_sel = write_slot;
    end
  end

  assign fill_after = full ? fill_count : fill_count + LW'(1);
  assign slot_inc   = (LW+1)'(slot) + (LW+1)'(1);
  assign dvsr       = XW'(den) << 1;
  assign dvd        = (XW'(mag) << (rbs_pkg::FRAC_W + 1)) + XW'(den);
  assign qv         = (q > (neg ? NEG_LIM : POS_LIM)) ? (neg ? NEG_LIM : POS_LIM) : q;

  always_comb begin
    if (32'(cfg_wr_data) < 32'(rbs_pkg::WINDOW_LEN_MIN)) begin
      wlen_wr = LW'(rbs_pkg::WINDOW_LEN_MIN);
    end else if (32'(cfg_wr_data) > 32'(WINDOW_MAX)) begin
      wlen_wr = LW'(WINDOW_MAX);
    end else begin
      wlen_wr = LW'(cfg_wr_data);
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_LOAD: begin ma = SXW'(ox);  mb = SXW'(oy);  end
      ST_M1:   begin ma = SXW'(oy);  mb = SXW'(oy);  end
      ST_M2:   begin ma = SXW'(xs);  mb = SXW'(ys);  end
      ST_M3:   begin ma = SXW'(ys);  mb = SXW'(ys);  end
      ST_P0:   begin ma = sum_x;     mb = sum_y;     end
      ST_P1:   begin ma = sum_y;     mb = sum_y;     end
      default: begin ma = '0;        mb = '0;        end
    endcase
  end

  assign sc_in = (state == ST_P0) ? sum_xy : sum_yy;

  always_ff @(posedge clk) begin
    p <= ma * mb;
    s <= $signed({1'b0, wlen}) * sc_in;
  end

  // history ring; read data registered
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ox <= x_mem[slot_sel];
      oy <= y_mem[slot_sel];
    end
    if (state == ST_LOAD) begin
      x_mem[slot] <= xs;
      y_mem[slot] <= ys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wlen       <= LW'(rbs_pkg::WINDOW_LEN_RST);
      fill_count <= '0;
      write_slot <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      sum_yy     <= '0;
      sum_xy     <= '0;
      out_valid  <= 1'b0;
    end else begin
      // in ST_OUT the output register is handled below
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            xs   <= x_sample;
            ys   <= y_sample;
            slot <= slot_sel;
            if (restart) begin
              sum_x      <= '0;
              sum_y      <= '0;
              sum_yy     <= '0;
              sum_xy     <= '0;
              fill_count <= '0;
              full       <= 1'b0;
            end else begin
              full <= (fill_count >= wlen);
            end
            state <= ST_LOAD;
          end
        end
        ST_LOAD: state <= ST_M1;
        ST_M1: begin
          if (full) sum_xy <= sum_xy - SQW'(p);
          state <= ST_M2;
        end
        ST_M2: begin
          if (full) sum_yy <= sum_yy - SQW'(p);
          state <= ST_M3;
        end
        ST_M3: begin
          sum_xy <= sum_xy + SQW'(p);
          state  <= ST_SUM;
        end
        ST_SUM: begin
          sum_yy     <= sum_yy + SQW'(p);
          sum_x      <= sum_x + SXW'(xs) - (full ? SXW'(ox) : SXW'(0));
          sum_y      <= sum_y + SXW'(ys) - (full ? SXW'(oy) : SXW'(0));
          fill_count <= fill_after;
          write_slot <= (slot_inc >= (LW+1)'(wlen)) ? '0 : AW'(slot_inc);
          if (fill_after >= wlen) begin
            state <= ST_P0;
          end else begin
            res_beta  <= '0;
            res_valid <= 1'b0;
            state     <= ST_OUT;
          end
        end
        ST_P0: state <= ST_P1;
        ST_P1: begin
          num   <= NW'(s) - NW'(p);
          state <= ST_P2;
        end
        ST_P2: begin
          den   <= NW'(s) - NW'(p);
          neg   <= num[NW-1];
          mag   <= num[NW-1] ? NW'(-num) : NW'(num);
          state <= ST_DSET;
        end
        ST_DSET: begin
          q   <= '0;
          cnt <= '0;
          rem <= dvd;
          dsh <= dvsr << (QW - 1);
          if (den == '0) begin
            res_beta  <= '0;
            res_valid <= 1'b0;
            state     <= ST_OUT;
          end else if (dvd >= (dvsr << QW)) begin
            // quotient beyond 32 bits
            res_beta  <= neg ? NEG_LIM : POS_LIM;
            res_valid <= 1'b1;
            state     <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            q   <= {q[QW-2:0], 1'b1};
          end else begin
            q <= {q[QW-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(QW - 1)) state <= ST_RND;
        end
        ST_RND: begin
          res_beta  <= neg ? QW'(-qv) : qv;
          res_valid <= 1'b1;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            beta       <= res_beta;
            beta_valid <= res_valid;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_wr_en) begin
        wlen       <= wlen_wr;
        fill_count <= '0;
        write_slot <= '0;
        sum_x      <= '0;
        sum_y      <= '0;
        sum_yy     <= '0;
        sum_xy     <= '0;
      end
    end
  end

endmodule
